// ----- src/simq_pkg.sv -----
// Package for the sorted insert min queue: operation and error codes,
// default sizes and the command struct shared by the top level and the cells.
// No dependencies.
`timescale 1ns / 1ps

package simq_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_EMPTY = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   typedef struct packed {
      logic push;
      logic pop;
   } simq_cmd_type;

endpackage

// ----- src/sorted_insert_min_queue_unit.sv -----
// A result is registered and shown in the cycle after its request transfer.
// Throughput: one push or pop per cycle while rsp is not stalled; each cell
// does one compare and one neighbor move per cycle, and the result register
// frees up on rsp transfer. Reset: synchronous, clears the entry count and
// the result valid; entry storage is not cleared, only read below the count.
`timescale 1ns / 1ps

module sorted_insert_min_queue_unit
   import simq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   localparam int CW         = $clog2(DEPTH + 1),
   localparam int REQ_W      = ((VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSP_W      = ((VALUE_WIDTH + CW + 3 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // value
   input  logic [0:0]       req_tuser,   // operation
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // error, top_value, top_valid, count
);

   logic signed [VALUE_WIDTH-1:0] value;
   logic                          accept;
   logic                          full;
   logic                          empty;
   simq_cmd_type                  cmd;
   logic [1:0]                    error;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [RSP_W-1:0]              rsp_data_ff;
   logic [RSP_W-1:0]              rsp_data_in;
   logic                          top_valid;
   logic signed [VALUE_WIDTH-1:0] top_value;

   logic                          shift_chain [DEPTH];
   logic signed [VALUE_WIDTH-1:0] entry_chain [DEPTH];
   logic signed [VALUE_WIDTH-1:0] next_chain  [DEPTH];

   assign value      = req_tdata[VALUE_WIDTH-1:0];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);

   always_comb begin
      cmd      = '{push: 1'b0, pop: 1'b0};
      error    = ERR_OK;
      count_in = count_ff;
      if (accept) begin
         if (req_tuser[0] == OP_PUSH) begin
            if (full) begin
               error = ERR_FULL;
            end else begin
               cmd.push = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               error = ERR_EMPTY;
            end else begin
               cmd.pop  = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                          left_shift;
      logic signed [VALUE_WIDTH-1:0] left_entry;
      logic signed [VALUE_WIDTH-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_shift = 1'b0;
         assign left_entry = value;
      end else begin : g_inner
         assign left_shift = shift_chain[i-1];
         assign left_entry = entry_chain[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = entry_chain[i+1];
      end

      simq_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .COUNT_WIDTH (CW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .value       (value),
         .count       (count_ff),
         .index       (CW'(i)),
         .left_shift  (left_shift),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .shift       (shift_chain[i]),
         .entry       (entry_chain[i]),
         .entry_next  (next_chain[i])
      );
   end

   assign top_valid = (count_in != '0);
   assign top_value = top_valid ? next_chain[0] : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({count_in, top_valid, top_value, error});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- src/simq_cell.sv -----
// One slot of the sorted chain: holds one entry, compares it with the pushed
// value and moves entries to or from its neighbors.
// Depends on simq_pkg.
`timescale 1ns / 1ps

module simq_cell
   import simq_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = 5
) (
   input  logic                          clock,
   input  simq_cmd_type                  cmd,
   input  logic signed [VALUE_WIDTH-1:0] value,
   input  logic [COUNT_WIDTH-1:0]        count,
   input  logic [COUNT_WIDTH-1:0]        index,
   input  logic                          left_shift,
   input  logic signed [VALUE_WIDTH-1:0] left_entry,
   input  logic signed [VALUE_WIDTH-1:0] right_entry,
   output logic                          shift,
   output logic signed [VALUE_WIDTH-1:0] entry,
   output logic signed [VALUE_WIDTH-1:0] entry_next
);

   logic signed [VALUE_WIDTH-1:0] entry_ff;
   logic signed [VALUE_WIDTH-1:0] entry_in;
   logic                          occupied;

   assign occupied = (count > index);
   assign shift    = occupied && (entry_ff >= value);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.push) begin
         if (left_shift) begin
            entry_in = left_entry;
         end else if (shift || !occupied) begin
            entry_in = value;
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

// ----- src/simq_checker.sv -----
// Port-level checks for sorted_insert_min_queue_unit, attached by bind.
// Depends on simq_pkg.
`timescale 1ns / 1ps

module simq_checker
   import simq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   localparam int CW         = $clog2(DEPTH + 1),
   localparam int RSP_W      = ((VALUE_WIDTH + CW + 3 + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic [1:0]             rsp_error;
   logic [VALUE_WIDTH-1:0] rsp_top_value;
   logic                   rsp_top_valid;
   logic [CW-1:0]          rsp_count;

   assign rsp_error     = rsp_tdata[1:0];
   assign rsp_top_value = rsp_tdata[VALUE_WIDTH+1:2];
   assign rsp_top_valid = rsp_tdata[VALUE_WIDTH+2];
   assign rsp_count     = rsp_tdata[VALUE_WIDTH+CW+2:VALUE_WIDTH+3];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer payload changed while stalled");

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("req transfer produced no rsp");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_top_valid == (rsp_count != '0)))
      else $error("top_valid disagrees with count");

   a_empty_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_error == ERR_EMPTY)
      |-> (rsp_count == '0) && !rsp_top_valid && (rsp_top_value == '0))
      else $error("pop on empty store reported a nonempty store");

   a_full_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_error == ERR_FULL) |-> (rsp_count == CW'(DEPTH)))
      else $error("push dropped while store not full");

endmodule

bind sorted_insert_min_queue_unit simq_checker #(
   .DEPTH       (DEPTH),
   .VALUE_WIDTH (VALUE_WIDTH)
) u_simq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/sv/tb_sorted_insert_min_queue_unit.sv -----
// Self-checking bench for sorted_insert_min_queue_unit: directed and random push/pop
// streams with random idling on both sides, checked against an in-bench sorted store.
// Depends on simq_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_sorted_insert_min_queue_unit;
   import simq_pkg::*;

   localparam int SLOTS  = 16;
   localparam int VW     = 32;
   localparam int REQ_W  = 32;
   localparam int RSP_W  = 40;
   localparam int QUIET_TAIL = 80;

   typedef struct packed {
      logic          op;
      logic [VW-1:0] value;
   } queue_cmd_type;

   typedef struct packed {
      logic [1:0]    error;
      logic [VW-1:0] top_value;
      logic          top_valid;
      logic [4:0]    count;
   } queue_status_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // value
   logic [0:0]       req_tuser = '0;   // operation
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;        // error, top_value, top_valid, count

   queue_cmd_type    pending_cmds[$];
   queue_status_type expected_status[$];

   logic signed [VW-1:0] model_slots[SLOTS];
   int                   model_count = 0;

   int  mismatches = 0;
   int  checked = 0;
   int  push_total = 0;
   int  pop_total = 0;
   int  full_drops = 0;
   int  empty_pops = 0;
   int  idle_left = 0;
   int  stall_left = 0;
   logic quiet = 1'b0;

   sorted_insert_min_queue_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // advance the sorted store by one command and queue the status it yields
   task automatic apply_command(input logic op, input logic [VW-1:0] value);
      queue_status_type st;
      int               pos;
      st.error = ERR_OK;
      if (op == OP_PUSH) begin
         push_total++;
         if (model_count >= SLOTS) begin
            st.error = ERR_FULL;
            full_drops++;
         end else begin
            pos = model_count;
            while (pos > 0 && !(model_slots[pos-1] >= $signed(value))) begin
               model_slots[pos] = model_slots[pos-1];
               pos--;
            end
            model_slots[pos] = value;
            model_count++;
         end
      end else begin
         pop_total++;
         if (model_count == 0) begin
            st.error = ERR_EMPTY;
            empty_pops++;
         end else begin
            model_count--;
         end
      end
      st.top_valid = (model_count > 0);
      st.top_value = (model_count > 0) ? model_slots[model_count-1] : '0;
      st.count     = model_count[4:0];
      expected_status.push_back(st);
   endtask

   function automatic logic [VW-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(0, 8) - 4;
         4: begin
            case ($urandom_range(0, 4))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hffff_ffff;
               default: return 32'h8000_0001;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_cmd(input logic op, input logic [VW-1:0] value);
      queue_cmd_type c;
      c.op    = op;
      c.value = value;
      pending_cmds.push_back(c);
   endtask

   always @(posedge clock) begin : driver
      queue_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_command(req_tuser[0], req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               c = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= c.value;
               req_tuser  <= c.op;
               if (!quiet && $urandom_range(0, 3) == 0) begin
                  idle_left = $urandom_range(1, 9);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         quiet <= (pending_cmds.size() < QUIET_TAIL);
      end
   end

   always @(posedge clock) begin : monitor
      queue_status_type exp_st;
      queue_status_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.error     = rsp_tdata[1:0];
            got.top_value = rsp_tdata[33:2];
            got.top_valid = rsp_tdata[34];
            got.count     = rsp_tdata[39:35];
            if (expected_status.size() == 0) begin
               $error("result transfer with nothing expected: %h", rsp_tdata);
               mismatches++;
            end else begin
               exp_st = expected_status.pop_front();
               checked++;
               if (got.error !== exp_st.error) begin
                  $error("error: expected %0d, got %0d", exp_st.error, got.error);
                  mismatches++;
               end
               if (got.top_value !== exp_st.top_value) begin
                  $error("top_value: expected %0d, got %0d",
                         $signed(exp_st.top_value), $signed(got.top_value));
                  mismatches++;
               end
               if (got.top_valid !== exp_st.top_valid) begin
                  $error("top_valid: expected %0d, got %0d",
                         exp_st.top_valid, got.top_valid);
                  mismatches++;
               end
               if (got.count !== exp_st.count) begin
                  $error("count: expected %0d, got %0d", exp_st.count, got.count);
                  mismatches++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 9);
            end
         end
      end
   end

   initial begin : stimulus
      int issued;
      int seg_len;
      int seg_kind;
      int k;
      // directed: empty pop, extremes, equal values, drain past empty
      queue_cmd(OP_POP, 32'hdead_beef);
      queue_cmd(OP_PUSH, 32'h7fff_ffff);
      queue_cmd(OP_PUSH, 32'h8000_0000);
      queue_cmd(OP_PUSH, 32'h0000_0000);
      queue_cmd(OP_PUSH, 32'hffff_ffff);
      queue_cmd(OP_PUSH, 32'd7);
      queue_cmd(OP_PUSH, 32'd7);
      queue_cmd(OP_PUSH, 32'h8000_0000);
      for (k = 0; k < 8; k++) begin
         queue_cmd(OP_POP, $urandom);
      end
      // random: runs of pushes, runs of pops and mixed stretches; start with a fill
      issued = 0;
      seg_kind = 0;
      seg_len = 19;
      while (issued < 600) begin
         for (k = 0; k < seg_len; k++) begin
            case (seg_kind)
               0: queue_cmd(OP_PUSH, pick_value());
               1: queue_cmd(OP_POP, $urandom);
               default: begin
                  if ($urandom_range(0, 9) < 6) begin
                     queue_cmd(OP_PUSH, pick_value());
                  end else begin
                     queue_cmd(OP_POP, $urandom);
                  end
               end
            endcase
         end
         issued += seg_len;
         seg_kind = $urandom_range(0, 3);
         seg_len = $urandom_range(8, 22);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() > 0 || req_tvalid || expected_status.size() > 0) begin
         @(posedge clock);
      end
      repeat (5) @(posedge clock);

      $display("checked %0d results: %0d pushes (%0d dropped when full), %0d pops (%0d on empty)",
               checked, push_total, full_drops, pop_total, empty_pops);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("timeout with %0d results outstanding", expected_status.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- sim.f -----
src/simq_pkg.sv
src/simq_cell.sv
src/sorted_insert_min_queue_unit.sv
src/simq_checker.sv
tb/sv/tb_sorted_insert_min_queue_unit.sv
